@@ rtl/sgpd_pkg.sv @@
// Shared constants for the segment pair distance block.
package sgpd_pkg;

  localparam int DIST_BITS = 21;

endpackage

@@ rtl/sgpd_pt_seg.sv @@
// Point to segment squared distance, scaled and truncated, as a deep pipeline.
module sgpd_pt_seg #(
  parameter int CB = 16,
  parameter int F  = 4,
  localparam int CW = 2 * CB + 2,
  localparam int VW = 2 * CB + 2 + 2 * F
) (
  input  logic                 clk,
  input  logic signed [CB-1:0] px,
  input  logic signed [CB-1:0] py,
  input  logic signed [CB-1:0] q1x,
  input  logic signed [CB-1:0] q1y,
  input  logic signed [CB-1:0] q2x,
  input  logic signed [CB-1:0] q2y,
  output logic        [VW-1:0] v
);

  localparam int MW = 2 * CB + 2;
  localparam int H  = CB + 1;
  localparam int NW = 2 * MW + 2 * F;

  // stage 1: differences
  logic signed [CB:0] e1x_r, e1y_r, e2x_r, e2y_r, gx_r, gy_r;

  always_ff @(posedge clk) begin
    e1x_r <= {px[CB-1], px} - {q1x[CB-1], q1x};
    e1y_r <= {py[CB-1], py} - {q1y[CB-1], q1y};
    e2x_r <= {px[CB-1], px} - {q2x[CB-1], q2x};
    e2y_r <= {py[CB-1], py} - {q2y[CB-1], q2y};
    gx_r  <= {q2x[CB-1], q2x} - {q1x[CB-1], q1x};
    gy_r  <= {q2y[CB-1], q2y} - {q1y[CB-1], q1y};
  end

  // stage 2: squares and cross terms
  logic signed [2*CB+1:0] m1x, m1y, m2x, m2y, mgx, mgy, p1_nxt, p2_nxt;
  logic [2*CB:0] s1x_r, s1y_r, s2x_r, s2y_r, sgx_r, sgy_r;
  logic signed [2*CB+1:0] p1_r, p2_r;

  assign m1x    = e1x_r * e1x_r;
  assign m1y    = e1y_r * e1y_r;
  assign m2x    = e2x_r * e2x_r;
  assign m2y    = e2y_r * e2y_r;
  assign mgx    = gx_r * gx_r;
  assign mgy    = gy_r * gy_r;
  assign p1_nxt = gx_r * e1y_r;
  assign p2_nxt = gy_r * e1x_r;

  always_ff @(posedge clk) begin
    s1x_r <= m1x[2*CB:0];
    s1y_r <= m1y[2*CB:0];
    s2x_r <= m2x[2*CB:0];
    s2y_r <= m2y[2*CB:0];
    sgx_r <= mgx[2*CB:0];
    sgy_r <= mgy[2*CB:0];
    p1_r  <= p1_nxt;
    p2_r  <= p2_nxt;
  end

  // stage 3: squared lengths and cross product magnitude
  logic signed [2*CB+2:0] cr;
  logic [2*CB+2:0] cr_abs;
  logic [CW-1:0] a_r, b_r, c_r;
  logic [MW-1:0] crm_r;

  assign cr     = {p1_r[2*CB+1], p1_r} - {p2_r[2*CB+1], p2_r};
  assign cr_abs = cr[2*CB+2] ? (2*CB+3)'(-cr) : (2*CB+3)'(cr);

  always_ff @(posedge clk) begin
    a_r   <= CW'(s1x_r) + CW'(s1y_r);
    b_r   <= CW'(s2x_r) + CW'(s2y_r);
    c_r   <= CW'(sgx_r) + CW'(sgy_r);
    crm_r <= cr_abs[MW-1:0];
  end

  // stage 4: endpoint tests, partial products of the squared cross product
  logic end1, end2;
  logic endf_r;
  logic [CW-1:0] endv_r, c4_r;
  logic [2*H-1:0] ll_r, lh_r, hh_r;

  assign end1 = {1'b0, a_r} >= ({1'b0, b_r} + {1'b0, c_r});
  assign end2 = {1'b0, b_r} >= ({1'b0, a_r} + {1'b0, c_r});

  always_ff @(posedge clk) begin
    endf_r <= end1 | end2;
    endv_r <= end1 ? b_r : a_r;
    c4_r   <= c_r;
    ll_r   <= crm_r[H-1:0] * crm_r[H-1:0];
    lh_r   <= crm_r[H-1:0] * crm_r[MW-1:H];
    hh_r   <= crm_r[MW-1:H] * crm_r[MW-1:H];
  end

  // stage 5: dividend and divisor
  logic [2*MW-1:0] crsq;
  logic [NW-1:0] num_r;
  logic [CW-1:0] den_r;

  assign crsq = {hh_r, ll_r} + ((2*MW)'(lh_r) << (H + 1));

  always_ff @(posedge clk) begin
    num_r <= endf_r ? (NW'(endv_r) << (2 * F)) : (NW'(crsq) << (2 * F));
    den_r <= endf_r ? CW'(1) : c4_r;
  end

  // restoring divider, one quotient bit per stage
  logic [CW-1:0] rem_p [0:VW];
  logic [VW-1:0] w_p   [0:VW];
  logic [CW-1:0] den_p [0:VW];

  assign rem_p[0] = num_r[NW-1:VW];
  assign w_p[0]   = num_r[VW-1:0];
  assign den_p[0] = den_r;

  for (genvar i = 1; i <= VW; i++) begin : g_div
    logic [CW:0] t;
    logic ge;
    assign t  = {rem_p[i-1], w_p[i-1][VW-1]};
    assign ge = t >= {1'b0, den_p[i-1]};
    always_ff @(posedge clk) begin
      rem_p[i] <= ge ? CW'(t - {1'b0, den_p[i-1]}) : CW'(t);
      w_p[i]   <= {w_p[i-1][VW-2:0], ge};
      den_p[i] <= den_p[i-1];
    end
  end

  assign v = w_p[VW];

endmodule

@@ rtl/segment_pair_distance.sv @@
// Segment pair distance: top level with four point-segment units, minimum and square root.
//
//  channel  ports                                  handshake
//  input    in_seg_a_*, in_seg_b_* (COORD_BITS)   start, busy (busy is always low)
//  result   out_distance (21 bits)                 out_valid, one-cycle strobe
//
// One request enters per cycle. The delay to its result is set mostly by the
// bit-per-stage divider and square root pipelines. Reset clears only the valid
// line. Nothing stalls: every stage advances on every clock.
module segment_pair_distance #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  in_seg_a_x1,
  input  logic signed [COORD_BITS-1:0]  in_seg_a_y1,
  input  logic signed [COORD_BITS-1:0]  in_seg_a_x2,
  input  logic signed [COORD_BITS-1:0]  in_seg_a_y2,
  input  logic signed [COORD_BITS-1:0]  in_seg_b_x1,
  input  logic signed [COORD_BITS-1:0]  in_seg_b_y1,
  input  logic signed [COORD_BITS-1:0]  in_seg_b_x2,
  input  logic signed [COORD_BITS-1:0]  in_seg_b_y2,
  output logic                          out_valid,
  output logic [sgpd_pkg::DIST_BITS-1:0] out_distance
);

  localparam int VW  = 2 * COORD_BITS + 2 + 2 * FRAC_BITS;
  localparam int RW  = COORD_BITS + 1 + FRAC_BITS;
  localparam int UL  = 5 + VW;
  localparam int LAT = UL + 2 + RW;

  assign busy = 1'b0;

  logic [VW-1:0] pv [0:3];

  sgpd_pt_seg #(.CB(COORD_BITS), .F(FRAC_BITS)) u_a1 (
    .clk(clk), .px(in_seg_a_x1), .py(in_seg_a_y1),
    .q1x(in_seg_b_x1), .q1y(in_seg_b_y1), .q2x(in_seg_b_x2), .q2y(in_seg_b_y2),
    .v(pv[0])
  );
  sgpd_pt_seg #(.CB(COORD_BITS), .F(FRAC_BITS)) u_a2 (
    .clk(clk), .px(in_seg_a_x2), .py(in_seg_a_y2),
    .q1x(in_seg_b_x1), .q1y(in_seg_b_y1), .q2x(in_seg_b_x2), .q2y(in_seg_b_y2),
    .v(pv[1])
  );
  sgpd_pt_seg #(.CB(COORD_BITS), .F(FRAC_BITS)) u_b1 (
    .clk(clk), .px(in_seg_b_x1), .py(in_seg_b_y1),
    .q1x(in_seg_a_x1), .q1y(in_seg_a_y1), .q2x(in_seg_a_x2), .q2y(in_seg_a_y2),
    .v(pv[2])
  );
  sgpd_pt_seg #(.CB(COORD_BITS), .F(FRAC_BITS)) u_b2 (
    .clk(clk), .px(in_seg_b_x2), .py(in_seg_b_y2),
    .q1x(in_seg_a_x1), .q1y(in_seg_a_y1), .q2x(in_seg_a_x2), .q2y(in_seg_a_y2),
    .v(pv[3])
  );

  // valid line
  logic [LAT-1:0] vld_r, vld_nxt;

  assign vld_nxt = {vld_r[LAT-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // minimum of scaled squared distances; sqrt is monotonic
  logic [VW-1:0] mn01_r, mn23_r, mn_r;

  always_ff @(posedge clk) begin
    mn01_r <= (pv[1] < pv[0]) ? pv[1] : pv[0];
    mn23_r <= (pv[3] < pv[2]) ? pv[3] : pv[2];
    mn_r   <= (mn23_r < mn01_r) ? mn23_r : mn01_r;
  end

  // restoring square root, one root bit per stage
  logic [VW-1:0]   sx_p   [0:RW];
  logic [RW+1:0]   srem_p [0:RW];
  logic [RW-1:0]   sroot_p[0:RW];

  assign sx_p[0]    = mn_r;
  assign srem_p[0]  = '0;
  assign sroot_p[0] = '0;

  for (genvar j = 1; j <= RW; j++) begin : g_sqrt
    logic [RW+3:0] t;
    logic [RW+3:0] trial;
    logic ge;
    assign t     = {srem_p[j-1], sx_p[j-1][VW-1:VW-2]};
    assign trial = {2'b00, sroot_p[j-1], 2'b01};
    assign ge    = t >= trial;
    always_ff @(posedge clk) begin
      srem_p[j]  <= ge ? (RW+2)'(t - trial) : (RW+2)'(t);
      sroot_p[j] <= {sroot_p[j-1][RW-2:0], ge};
      sx_p[j]    <= {sx_p[j-1][VW-3:0], 2'b00};
    end
  end

  assign out_valid    = vld_r[LAT-1];
  assign out_distance = sgpd_pkg::DIST_BITS'(sroot_p[RW]);

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching request");

  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("request lost in pipeline");

  a_min: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[UL] |-> (mn01_r <= $past(pv[0]) && mn01_r <= $past(pv[1])
                   && mn23_r <= $past(pv[2]) && mn23_r <= $past(pv[3])))
    else $error("min stage above an input");

  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] |-> (sroot_p[RW] <= $past(sroot_p[RW-1], 1) * 2 + 1))
    else $error("square root stage inconsistent");

endmodule
